// File: hdl/mhss_pkg.sv
// Package for the mail header section scanner.
// Holds character codes, event codes, line ending codes and the name character test.
// No dependencies.
package mhss_pkg;

    localparam int EVENT_BITS = 3;
    localparam int STYLE_BITS = 2;

    // event codes
    localparam logic [EVENT_BITS-1:0] EV_NONE       = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_NAME_COLON = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_BODY_START = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_UNEXPECTED = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_BAD_FIRST  = 3'd4;
    localparam logic [EVENT_BITS-1:0] EV_BARE_CR    = 3'd5;

    // line ending styles
    localparam logic [STYLE_BITS-1:0] STYLE_UNKNOWN = 2'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_LF      = 2'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_CRLF    = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // printable, not space, not colon
    function automatic logic name_char(input logic [7:0] b);
        name_char = (b > CH_SP) && (b < CH_DEL) && (b != CH_COLON);
    endfunction

endpackage

// File: hdl/mhss_step.sv
// Per-byte scan step: scanner state registers and the classification logic.
// Results for the presented byte appear combinationally; state advances on accept.
// Depends on mhss_pkg.
module mhss_step #(
    parameter int HDR_BITS    = 13,
    parameter int NAME_BITS   = 10,
    parameter int OFFSET_BITS = 24,
    parameter int MAX_HEADERS = 4096,
    parameter int NAME_LEN_MAX = 1023
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [7:0]                          data_byte,
    input  logic                                first_byte,
    output logic [mhss_pkg::EVENT_BITS-1:0]     event_res,
    output logic [HDR_BITS-1:0]                 header_total,
    output logic [NAME_BITS-1:0]                name_length,
    output logic [OFFSET_BITS-1:0]              byte_offset,
    output logic [mhss_pkg::STYLE_BITS-1:0]     crlf_mode
);
    import mhss_pkg::*;

    logic [OFFSET_BITS-1:0] offset_count_reg, offset_count_next;
    logic                   at_line_start_reg, at_line_start_next;
    logic                   in_name_reg, in_name_next;
    logic [NAME_BITS-1:0]   name_count_reg, name_count_next;
    logic [HDR_BITS-1:0]    header_count_reg, header_count_next;
    logic [STYLE_BITS-1:0]  ending_style_reg, ending_style_next;
    logic                   cr_pending_reg, cr_pending_next;
    logic                   empty_cr_pending_reg, empty_cr_pending_next;
    logic                   scan_done_reg, scan_done_next;

    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] off_inc;
    logic                   content;

    always_comb
    begin
        // first byte of a message starts from the reset state
        off                   = first_byte ? '0 : offset_count_reg;
        at_line_start_next    = first_byte ? 1'b1 : at_line_start_reg;
        in_name_next          = first_byte ? 1'b0 : in_name_reg;
        name_count_next       = first_byte ? '0 : name_count_reg;
        header_count_next     = first_byte ? '0 : header_count_reg;
        ending_style_next     = first_byte ? STYLE_UNKNOWN : ending_style_reg;
        cr_pending_next       = first_byte ? 1'b0 : cr_pending_reg;
        empty_cr_pending_next = first_byte ? 1'b0 : empty_cr_pending_reg;
        scan_done_next        = first_byte ? 1'b0 : scan_done_reg;

        off_inc     = (off == '1) ? off : off + 1'b1;
        event_res   = EV_NONE;
        name_length = '0;
        byte_offset = off;
        content     = 1'b0;

        if (first_byte && !name_char(data_byte))
        begin
            event_res      = EV_BAD_FIRST;
            scan_done_next = 1'b1;
        end
        else if (!scan_done_next)
        begin
            if (cr_pending_next)
            begin
                cr_pending_next = 1'b0;
                if (data_byte == CH_LF)
                begin
                    ending_style_next  = STYLE_CRLF;
                    at_line_start_next = 1'b1;
                end
                else
                begin
                    event_res = EV_BARE_CR;
                    content   = 1'b1;
                end
            end
            else if (empty_cr_pending_next)
            begin
                empty_cr_pending_next = 1'b0;
                if (data_byte == CH_LF)
                begin
                    event_res      = EV_BODY_START;
                    byte_offset    = off_inc;
                    scan_done_next = 1'b1;
                end
                else
                begin
                    event_res = EV_UNEXPECTED;
                    content   = 1'b1;
                end
            end
            else if (at_line_start_next)
            begin
                at_line_start_next = 1'b0;
                if (name_char(data_byte))
                begin
                    if (header_count_next < HDR_BITS'(MAX_HEADERS))
                        header_count_next = header_count_next + 1'b1;
                    in_name_next    = 1'b1;
                    name_count_next = NAME_BITS'(1);
                end
                else if (data_byte == CH_CR && ending_style_next == STYLE_CRLF)
                begin
                    empty_cr_pending_next = 1'b1;
                end
                else if (data_byte == CH_LF && ending_style_next == STYLE_LF)
                begin
                    event_res      = EV_BODY_START;
                    byte_offset    = off_inc;
                    scan_done_next = 1'b1;
                end
                else if (data_byte == CH_SP || data_byte == CH_TAB)
                begin
                    in_name_next = 1'b0;
                end
                else
                begin
                    event_res = EV_UNEXPECTED;
                    content   = 1'b1;
                end
            end
            else if (in_name_next)
            begin
                if (data_byte == CH_COLON)
                begin
                    event_res    = EV_NAME_COLON;
                    name_length  = name_count_next;
                    in_name_next = 1'b0;
                end
                else if (data_byte == CH_CR || data_byte == CH_LF)
                begin
                    in_name_next = 1'b0;
                    content      = 1'b1;
                end
                else if (name_count_next < NAME_BITS'(NAME_LEN_MAX))
                begin
                    name_count_next = name_count_next + 1'b1;
                end
            end
            else
            begin
                content = 1'b1;
            end
        end

        // ordinary line content: CR waits for LF, LF ends the line
        if (content)
        begin
            if (data_byte == CH_CR)
                cr_pending_next = 1'b1;
            else if (data_byte == CH_LF)
            begin
                if (ending_style_next == STYLE_UNKNOWN)
                    ending_style_next = STYLE_LF;
                at_line_start_next = 1'b1;
            end
        end

        offset_count_next = off_inc;
        header_total      = header_count_next;
        crlf_mode         = ending_style_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_count_reg     <= '0;
            at_line_start_reg    <= 1'b1;
            in_name_reg          <= 1'b0;
            name_count_reg       <= '0;
            header_count_reg     <= '0;
            ending_style_reg     <= STYLE_UNKNOWN;
            cr_pending_reg       <= 1'b0;
            empty_cr_pending_reg <= 1'b0;
            scan_done_reg        <= 1'b0;
        end
        else if (advance)
        begin
            offset_count_reg     <= offset_count_next;
            at_line_start_reg    <= at_line_start_next;
            in_name_reg          <= in_name_next;
            name_count_reg       <= name_count_next;
            header_count_reg     <= header_count_next;
            ending_style_reg     <= ending_style_next;
            cr_pending_reg       <= cr_pending_next;
            empty_cr_pending_reg <= empty_cr_pending_next;
            scan_done_reg        <= scan_done_next;
        end
    end

endmodule

// File: hdl/mail_header_section_scanner_core.sv
// Top level of the mail header section scanner: stream ports and output buffer.
// Instantiates mhss_step; depends on mhss_pkg.
//
// The scanner takes one message byte per beat on the slave stream (s_tuser set on
// the first byte of a message) and returns exactly one result beat per input beat,
// in order. Each accepted byte's result is registered into the output buffer. The
// scan state is updated in the accepting cycle by a single pass of compares and
// counter increments, so throughput is one byte per clock while s_tready is high.
// A two-entry output buffer (result register plus skid register) separates the two
// sides: input keeps flowing while one result waits, and s_tready drops only when
// both entries are full. Header count, name length and byte offset saturate; their
// widths follow MAX_HEADERS, NAME_LEN_MAX and OFFSET_BITS.
module mail_header_section_scanner_core #(
    parameter int MAX_HEADERS  = 4096,
    parameter int OFFSET_BITS  = 24,
    parameter int NAME_LEN_MAX = 1023,
    localparam int HDR_BITS    = $clog2(MAX_HEADERS + 1),
    localparam int NAME_BITS   = $clog2(NAME_LEN_MAX + 1),
    localparam int RES_BITS    = mhss_pkg::EVENT_BITS + HDR_BITS + NAME_BITS
                                 + OFFSET_BITS + mhss_pkg::STYLE_BITS,
    localparam int TDATA_BITS  = ((RES_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic                  s_tuser,   // first_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // event_res, header_total, name_length, byte_offset, crlf_mode, zero pad
    output logic [TDATA_BITS-1:0] m_tdata
);
    import mhss_pkg::*;

    logic                  push;
    logic                  pop;
    logic [EVENT_BITS-1:0] event_res;
    logic [HDR_BITS-1:0]   header_total;
    logic [NAME_BITS-1:0]  name_length;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [STYLE_BITS-1:0] crlf_mode;
    logic [TDATA_BITS-1:0] result_beat;

    logic                  main_valid_reg;
    logic [TDATA_BITS-1:0] main_data_reg;
    logic                  skid_valid_reg;
    logic [TDATA_BITS-1:0] skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign push     = s_tvalid && s_tready;
    assign pop      = main_valid_reg && m_tready;

    mhss_step #(
        .HDR_BITS     (HDR_BITS),
        .NAME_BITS    (NAME_BITS),
        .OFFSET_BITS  (OFFSET_BITS),
        .MAX_HEADERS  (MAX_HEADERS),
        .NAME_LEN_MAX (NAME_LEN_MAX)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (push),
        .data_byte    (s_tdata),
        .first_byte   (s_tuser),
        .event_res    (event_res),
        .header_total (header_total),
        .name_length  (name_length),
        .byte_offset  (byte_offset),
        .crlf_mode    (crlf_mode)
    );

    // pack fields, first field lowest, zero padded to whole bytes
    assign result_beat = TDATA_BITS'({crlf_mode, byte_offset, name_length,
                                      header_total, event_res});

    // control of the two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // input is stalled; drain skid into main on pop
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push && main_valid_reg && !pop)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload of the output buffer
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_data_reg <= skid_data_reg;
        end
        else if (push && main_valid_reg && !pop)
        begin
            skid_data_reg <= result_beat;
        end
        else if (push)
        begin
            main_data_reg <= result_beat;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

endmodule
